FILE: rtl/lpds_pkg.sv
// Package for the linear progression divisor scan core.
// Holds field widths, register indexes and the stage control struct.
// No dependencies.
package lpds_pkg;

  localparam int unsigned IdxW   = 62;
  localparam int unsigned TgtHiW = 61;
  localparam int unsigned TgtLoW = 64;
  localparam int unsigned TgtW   = TgtHiW + TgtLoW;
  localparam int unsigned SlopeW = 62;
  localparam int unsigned OffW   = 62;
  localparam int unsigned FirstW = 63;
  localparam int unsigned CandW  = 64;
  localparam int unsigned ProdW  = 126;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned DataW  = 64;

  typedef enum logic [2:0] {
    RegTargetHigh  = 3'd0,
    RegTargetLow   = 3'd1,
    RegSlope       = 3'd2,
    RegOffset      = 3'd3,
    RegFirst       = 3'd4
  } reg_idx_e;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic            valid;
    logic            last;
    logic            gt;
    logic [IdxW-1:0] idx;
  } ctrl_t;

endpackage

FILE: rtl/lpds_div_stage.sv
// One restoring division step of the remainder pipeline.
// Depends on lpds_pkg for widths and the control struct.
module lpds_div_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  lpds_pkg::ctrl_t             ctrl_i,
  input  logic [lpds_pkg::ProdW-1:0]  rem_i,
  input  logic [lpds_pkg::ProdW-1:0]  u_i,
  input  logic                        nbit_i,
  output lpds_pkg::ctrl_t             ctrl_o,
  output logic [lpds_pkg::ProdW-1:0]  rem_o,
  output logic [lpds_pkg::ProdW-1:0]  u_o
);
  import lpds_pkg::*;

  logic [ProdW:0]   shifted;
  logic [ProdW:0]   diff;
  logic [ProdW-1:0] rem_d;
  ctrl_t            ctrl_q;
  logic [ProdW-1:0] rem_q;
  logic [ProdW-1:0] u_q;

  // The remainder stays below u, so the shifted value fits one extra bit.
  always_comb begin
    shifted = {rem_i, nbit_i};
    diff    = shifted - {1'b0, u_i};
    rem_d   = (shifted >= {1'b0, u_i}) ? diff[ProdW-1:0] : shifted[ProdW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      u_q   <= u_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign u_o    = u_q;

endmodule

FILE: rtl/linear_progression_divisor_scan_core.sv
// Top level of the linear progression divisor scan core.
// Depends on lpds_pkg and lpds_div_stage.
//
// Each transfer on the input channel carries a candidate index i; the core forms
// q = first_candidate + 2*i, the 126-bit product D*q with D = slope_value, and,
// when D*q exceeds P = offset_value, tests whether u = D*q - P divides the 125-bit
// target N. One result transfer leaves for every input transfer, in order, with the
// index, the pass flag and the end-of-scan mark. The core accepts one index per clock
// cycle while the output is not stalled. The stages in order are the candidate add,
// the product (built from four partial products of D and q, then their sum), the
// compare and subtract against P, the restoring remainder pipeline (one target bit
// per stage), and the output register. A stall on the output holds the whole pipeline
// in place; bubbles are not squeezed out. Configuration registers sit on the APB
// port at byte address 8*i and must be written only while the pipeline is empty.
module linear_progression_divisor_scan_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpds_pkg::AddrW-1:0]    paddr,
  input  logic [lpds_pkg::DataW-1:0]    pwdata,
  output logic [lpds_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpds_pkg::IdxW-1:0]     candidate_index_i,
  input  logic                          last_candidate_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpds_pkg::IdxW-1:0]     result_index_o,
  output logic                          divides_o,
  output logic                          last_result_o
);
  import lpds_pkg::*;

  // Configuration registers.
  logic [TgtHiW-1:0] target_high_q;
  logic [TgtLoW-1:0] target_low_q;
  logic [SlopeW-1:0] slope_q;
  logic [OffW-1:0]   offset_q;
  logic [FirstW-1:0] first_q;
  logic [TgtW-1:0]   target;
  reg_idx_e          widx;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[AddrW-1:3]);
  assign target = {target_high_q, target_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_high_q <= '0;
      target_low_q  <= '0;
      slope_q       <= SlopeW'(1);
      offset_q      <= '0;
      first_q       <= FirstW'(1);
    end else if (cfg_we) begin
      case (widx)
        RegTargetHigh: target_high_q <= pwdata[TgtHiW-1:0];
        RegTargetLow:  target_low_q  <= pwdata[TgtLoW-1:0];
        RegSlope:      slope_q       <= pwdata[SlopeW-1:0];
        RegOffset:     offset_q      <= pwdata[OffW-1:0];
        RegFirst:      first_q       <= pwdata[FirstW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      RegTargetHigh: prdata = DataW'(target_high_q);
      RegTargetLow:  prdata = DataW'(target_low_q);
      RegSlope:      prdata = DataW'(slope_q);
      RegOffset:     prdata = DataW'(offset_q);
      RegFirst:      prdata = DataW'(first_q);
      default:       prdata = '0;
    endcase
  end

  // The whole pipeline moves together; the last stage is the output register.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: candidate q.
  ctrl_t            s1_q;
  logic [CandW-1:0] q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en) begin
      s1_q <= '{valid: in_valid_i, last: last_candidate_i, gt: 1'b0,
                idx: candidate_index_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q <= {1'b0, first_q} + {1'b0, candidate_index_i, 1'b0};
    end
  end

  // Stage 2: four partial products of D and q.
  ctrl_t        s2_q;
  logic [63:0]  p00_q;
  logic [63:0]  p01_q;
  logic [61:0]  p10_q;
  logic [61:0]  p11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en) begin
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p00_q <= slope_q[31:0] * q_q[31:0];
      p01_q <= slope_q[31:0] * q_q[63:32];
      p10_q <= slope_q[61:32] * q_q[31:0];
      p11_q <= slope_q[61:32] * q_q[63:32];
    end
  end

  // Stage 3: product sum; the true product stays below 2^126.
  ctrl_t            s3_q;
  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (en) begin
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= {62'd0, p00_q} + {30'd0, p01_q, 32'd0}
              + {32'd0, p10_q, 32'd0} + {p11_q, 64'd0};
    end
  end

  // Stage 4: compare against P and form the divisor u.
  ctrl_t            s4_q;
  logic [ProdW-1:0] u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (en) begin
      s4_q <= '{valid: s3_q.valid, last: s3_q.last, gt: prod_q > ProdW'(offset_q),
                idx: s3_q.idx};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= prod_q - ProdW'(offset_q);
    end
  end

  // Remainder pipeline: stage j brings in target bit TgtW-1-j.
  ctrl_t            dv_ctrl [TgtW];
  logic [ProdW-1:0] dv_rem  [TgtW];
  logic [ProdW-1:0] dv_u    [TgtW];

  for (genvar j = 0; j < TgtW; j++) begin : g_div
    if (j == 0) begin : g_first
      lpds_div_stage u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .ctrl_i (s4_q),
        .rem_i  ('0),
        .u_i    (u_q),
        .nbit_i (target[TgtW-1]),
        .ctrl_o (dv_ctrl[j]),
        .rem_o  (dv_rem[j]),
        .u_o    (dv_u[j])
      );
    end else begin : g_next
      lpds_div_stage u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .ctrl_i (dv_ctrl[j-1]),
        .rem_i  (dv_rem[j-1]),
        .u_i    (dv_u[j-1]),
        .nbit_i (target[TgtW-1-j]),
        .ctrl_o (dv_ctrl[j]),
        .rem_o  (dv_rem[j]),
        .u_o    (dv_u[j])
      );
    end
  end

  // The final stage's remainder only feeds the zero test; its u copy is not needed.
  logic [ProdW-1:0] u_unused;
  assign u_unused = dv_u[TgtW-1];

  // Output register.
  ctrl_t out_q;
  logic  divides_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q     <= '0;
      divides_q <= 1'b0;
    end else if (en) begin
      out_q     <= dv_ctrl[TgtW-1];
      divides_q <= dv_ctrl[TgtW-1].gt && (dv_rem[TgtW-1] == '0) && (u_unused == u_unused);
    end
  end

  assign out_valid_o    = out_q.valid;
  assign result_index_o = out_q.idx;
  assign divides_o      = divides_q;
  assign last_result_o  = out_q.last;

  // A pass is only ever flagged for an item whose product exceeded the offset.
  a_pass_needs_gt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divides_o |-> out_q.gt)
    else $error("pass flagged without product above offset");

  // Valid bits advance one stage per enabled cycle.
  a_valid_travels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && s1_q.valid |=> s2_q.valid)
    else $error("item lost between first and second stage");

  // A stall freezes the remainder pipeline.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_rem[TgtW-1]) && $stable(dv_ctrl[TgtW-1]))
    else $error("remainder pipeline moved during stall");

endmodule
